FILE: sv/ab2lp_pkg.sv
// Shared types and constants for the Annex-B to length-prefixed converter.
// No dependencies; used by every module of the block.
package ab2lp_pkg;

  localparam int CNT_W        = 31;
  localparam int PREFIX_BYTES = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_ESC  = 8'h03;

  // two zeros seen: start-code prefix in the scanner, escape window in the cleaner
  localparam logic [1:0] ZERO_PAIR = 2'd2;
  localparam logic [1:0] ZRUN_MAX  = 2'd3;

  localparam logic [CNT_W-1:0] CAP_RESET = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_LENGTH,
    KIND_OK,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_AWAIT,
    SCAN_INSIDE
  } scan_state_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_TAIL,
    BK_LENGTH,
    BK_DONE
  } bk_state_t;

  // Work for one input byte: commit 'zeros' zero bytes, then optionally
  // 'data', then optionally close the unit, then optionally finish the stream.
  typedef struct packed {
    logic [1:0] zeros;
    logic       has_byte;
    logic [7:0] data;
    logic       close;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             cmd_end;
    kind_t            kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] length;
    logic [CNT_W-1:0] total;
  } evt_t;

endpackage

FILE: sv/annexb_to_length_prefixed_nal_unit.sv
// Annex-B start-code stream to length-prefixed units with emulation prevention
// removal. One raw byte enters per cycle while the 4-entry command queue has
// room. The cleaning back end handles each committed byte as one step: a byte
// that releases held zeros (up to two) commits each zero as its own step first,
// an escape 03 followed by a byte above 03 needs an extra step, and a unit close
// or end of stream is a step of its own (the close needs an extra step when a
// trailing 03 is flushed). The queue absorbs these bursts. No clearing pass
// after reset.
// Top level; depends on ab2lp_pkg, ab2lp_front, ab2lp_queue, ab2lp_back, ab2lp_emit.
module annexb_to_length_prefixed_nal_unit import ab2lp_pkg::*; #(
  parameter int COUNT_BITS = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  logic [7:0]       data_byte,
  input  logic             end_of_stream,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       item_kind,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] out_offset,
  output logic [CNT_W-1:0] unit_length,
  output logic [CNT_W-1:0] total_written,
  output logic             last_of_run,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_OUTPUT_CAPACITY = 1'b0;

  logic [CNT_W-1:0] capacity;
  logic             cap_sel;
  logic             accept;
  cmd_t             cmd;
  logic             cmd_nonempty;
  logic             q_full;
  logic             head_valid;
  cmd_t             head;
  logic             pop;
  logic             advance;
  evt_t             evt;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == REG_OUTPUT_CAPACITY);
  assign prdata  = cap_sel ? {1'b0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  assign src_stall = q_full;
  assign accept    = src_valid && !q_full;

  ab2lp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .cmd          (cmd),
    .cmd_nonempty (cmd_nonempty)
  );

  ab2lp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && cmd_nonempty),
    .push_cmd  (cmd),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  ab2lp_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .advance   (advance),
    .capacity  (capacity),
    .pop       (pop),
    .evt       (evt)
  );

  ab2lp_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .evt          (evt),
    .advance      (advance),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .item_kind    (item_kind),
    .out_byte     (out_byte),
    .out_offset   (out_offset),
    .unit_length  (unit_length),
    .total_written(total_written),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: sv/ab2lp_front.sv
// Front end: start-code scanner that turns each input byte into one command.
// Depends on ab2lp_pkg.
module ab2lp_front import ab2lp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output cmd_t       cmd,
  output logic       cmd_nonempty
);

  scan_state_t scan_state, scan_state_next;
  logic [1:0]  hz, hz_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= SCAN_SEARCH;
    end else if (accept) begin
      scan_state <= scan_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hz <= 2'd0;
    end else if (accept) begin
      hz <= hz_next;
    end
  end

  always_comb begin
    scan_state_next = scan_state;
    hz_next         = hz;
    cmd             = '0;
    cmd.data        = data_byte;
    cmd.done        = end_of_stream;
    unique case (scan_state)
      SCAN_SEARCH: begin
        if (data_byte == BYTE_ZERO) begin
          hz_next = (hz == ZERO_PAIR) ? ZERO_PAIR : hz + 2'd1;
        end else if (data_byte == BYTE_ONE && hz == ZERO_PAIR) begin
          scan_state_next = SCAN_AWAIT;
          hz_next         = 2'd0;
        end else begin
          hz_next = 2'd0;
        end
      end
      SCAN_AWAIT: begin
        // first unit byte is payload whatever its value
        cmd.has_byte    = 1'b1;
        cmd.close       = end_of_stream;
        scan_state_next = SCAN_INSIDE;
        hz_next         = 2'd0;
      end
      SCAN_INSIDE: begin
        if (data_byte == BYTE_ZERO) begin
          if (end_of_stream) begin
            // held zeros plus this one all flush at the end
            cmd.zeros = hz + 2'd1;
            cmd.close = 1'b1;
          end else if (hz == ZERO_PAIR) begin
            cmd.has_byte = 1'b1;
          end else begin
            hz_next = hz + 2'd1;
          end
        end else if (data_byte == BYTE_ONE && hz == ZERO_PAIR) begin
          cmd.close       = 1'b1;
          scan_state_next = SCAN_AWAIT;
          hz_next         = 2'd0;
        end else begin
          cmd.zeros    = hz;
          cmd.has_byte = 1'b1;
          cmd.close    = end_of_stream;
          hz_next      = 2'd0;
        end
      end
      default: begin
        scan_state_next = SCAN_SEARCH;
        hz_next         = 2'd0;
      end
    endcase
    if (end_of_stream) begin
      scan_state_next = SCAN_SEARCH;
      hz_next         = 2'd0;
    end
  end

  assign cmd_nonempty = (cmd.zeros != 2'd0) || cmd.has_byte || cmd.close || cmd.done;

endmodule

FILE: sv/ab2lp_queue.sv
// Short command queue between the scanner and the cleaner.
// Depends on ab2lp_pkg (cmd_t, QUEUE_DEPTH).
module ab2lp_queue import ab2lp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

endmodule

FILE: sv/ab2lp_back.sv
// Back end: escape removal, unit counters, capacity check and result generation.
// Executes one step of the head command per cycle while the result stage can advance. Depends on ab2lp_pkg.
module ab2lp_back import ab2lp_pkg::*; #(
  parameter int COUNT_BITS = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             head,
  input  logic             head_valid,
  input  logic             advance,
  input  logic [CNT_W-1:0] capacity,
  output logic             pop,
  output evt_t             evt
);

  localparam int SUM_W = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 2;
  localparam logic [COUNT_BITS-1:0] RAW_MAX = {COUNT_BITS{1'b1}};

  bk_state_t             bk_state, bk_state_next;
  logic [1:0]            zcnt, zcnt_next;
  logic                  byte_taken, byte_taken_next;
  logic                  pending, pending_next;
  logic [1:0]            ezr, ezr_next;
  logic [COUNT_BITS-1:0] raw, raw_next;
  logic [COUNT_BITS-1:0] clean, clean_next;
  logic [CNT_W-1:0]      bw, bw_next;
  logic                  error, error_next;

  logic                  zero_op;
  logic [7:0]            commit_val;
  logic [1:0]            ezr_eff;
  logic [SUM_W-1:0]      need;
  logic                  err_commit;
  logic [CNT_W-1:0]      clean_w;
  logic [CNT_W-1:0]      clean_off;
  logic                  emit_en;
  logic [7:0]            emit_val;
  logic                  do_length;
  logic                  do_done;
  logic                  cmd_end;
  logic                  commit_op;

  assign zero_op    = (zcnt != head.zeros);
  assign commit_val = zero_op ? BYTE_ZERO : head.data;
  assign ezr_eff    = pending ? 2'd0 : ezr;
  // raw count after this commit, plus this unit's prefix, against capacity
  assign need       = SUM_W'(bw) + SUM_W'(raw) + SUM_W'(PREFIX_BYTES + 1);
  assign err_commit = error || (raw == RAW_MAX) || (need > SUM_W'(capacity));
  assign clean_w    = CNT_W'(clean);
  assign clean_off  = bw + clean_w + CNT_W'(PREFIX_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state <= BK_RUN;
    end else if (advance) begin
      bk_state <= bk_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zcnt       <= 2'd0;
      byte_taken <= 1'b0;
      pending    <= 1'b0;
      ezr        <= 2'd0;
      raw        <= '0;
      clean      <= '0;
      bw         <= '0;
      error      <= 1'b0;
    end else if (advance) begin
      zcnt       <= zcnt_next;
      byte_taken <= byte_taken_next;
      pending    <= pending_next;
      ezr        <= ezr_next;
      raw        <= raw_next;
      clean      <= clean_next;
      bw         <= bw_next;
      error      <= error_next;
    end
  end

  always_comb begin
    bk_state_next   = bk_state;
    zcnt_next       = zcnt;
    byte_taken_next = byte_taken;
    pending_next    = pending;
    ezr_next        = ezr;
    raw_next        = raw;
    clean_next      = clean;
    bw_next         = bw;
    error_next      = error;
    emit_en         = 1'b0;
    emit_val        = commit_val;
    do_length       = 1'b0;
    do_done         = 1'b0;
    cmd_end         = 1'b0;
    commit_op       = 1'b0;
    evt             = '0;

    unique case (bk_state)
      BK_RUN: begin
        if (head_valid) begin
          if (zero_op || (head.has_byte && !byte_taken)) begin
            commit_op  = 1'b1;
            raw_next   = (raw == RAW_MAX) ? raw : raw + 1'b1;
            error_next = err_commit;
            if (pending && commit_val > BYTE_ESC) begin
              // held 03 is real payload: emit it now, the byte from BK_TAIL
              pending_next  = 1'b0;
              ezr_next      = 2'd0;
              emit_en       = 1'b1;
              emit_val      = BYTE_ESC;
              bk_state_next = BK_TAIL;
            end else begin
              pending_next = 1'b0;
              if (ezr_eff == ZERO_PAIR && commit_val == BYTE_ESC) begin
                pending_next = 1'b1;
              end else begin
                emit_en  = 1'b1;
                ezr_next = (commit_val != BYTE_ZERO) ? 2'd0 :
                           (ezr_eff == ZRUN_MAX) ? ZRUN_MAX : ezr_eff + 2'd1;
              end
              if (zero_op) begin
                zcnt_next = zcnt + 2'd1;
                cmd_end   = (zcnt + 2'd1 == head.zeros) && !head.has_byte &&
                            !head.close && !head.done;
              end else begin
                byte_taken_next = 1'b1;
                cmd_end         = !head.close && !head.done;
              end
            end
          end else if (head.close) begin
            if (pending) begin
              // an 03 left at the end of a unit is kept
              pending_next  = 1'b0;
              emit_en       = 1'b1;
              emit_val      = BYTE_ESC;
              bk_state_next = BK_LENGTH;
            end else begin
              do_length = 1'b1;
              cmd_end   = !head.done;
              if (head.done) begin
                bk_state_next = BK_DONE;
              end
            end
          end else begin
            do_done = 1'b1;
            cmd_end = 1'b1;
          end
        end
      end
      BK_TAIL: begin
        emit_en         = 1'b1;
        emit_val        = head.data;
        ezr_next        = 2'd0;
        byte_taken_next = 1'b1;
        bk_state_next   = BK_RUN;
        cmd_end         = !head.close && !head.done;
      end
      BK_LENGTH: begin
        do_length     = 1'b1;
        cmd_end       = !head.done;
        bk_state_next = BK_DONE;
      end
      BK_DONE: begin
        do_done = 1'b1;
        cmd_end = 1'b1;
      end
      default: begin
        bk_state_next = BK_RUN;
      end
    endcase

    if (emit_en && !(commit_op ? err_commit : error)) begin
      evt.valid  = 1'b1;
      evt.kind   = KIND_BYTE;
      evt.data   = emit_val;
      evt.offset = clean_off;
      evt.total  = bw;
      clean_next = clean + 1'b1;
    end

    if (do_length) begin
      if (raw != '0 && !error) begin
        evt.valid  = 1'b1;
        evt.kind   = KIND_LENGTH;
        evt.offset = bw;
        evt.length = clean_w;
        evt.total  = clean_off;
        bw_next    = clean_off;
      end
      raw_next   = '0;
      clean_next = '0;
      ezr_next   = 2'd0;
    end

    if (do_done) begin
      evt.valid    = 1'b1;
      evt.kind     = (error || bw == '0) ? KIND_ERROR : KIND_OK;
      evt.total    = bw;
      raw_next     = '0;
      clean_next   = '0;
      bw_next      = '0;
      error_next   = 1'b0;
      pending_next = 1'b0;
      ezr_next     = 2'd0;
    end

    if (cmd_end) begin
      bk_state_next   = BK_RUN;
      zcnt_next       = 2'd0;
      byte_taken_next = 1'b0;
    end

    evt.cmd_end = cmd_end;
    pop         = cmd_end && advance;
  end

  // a held 03 only exists right after two cleaned zeros
  a_pending_run: assert property (@(posedge clk) disable iff (rst)
    pending |-> ezr == ZERO_PAIR)
    else $error("escape pending without a zero pair");

  // mid-command states need the command still at the queue head
  a_state_head: assert property (@(posedge clk) disable iff (rst)
    (bk_state != BK_RUN) |-> head_valid)
    else $error("back end mid-command with empty queue");

  a_clean_raw: assert property (@(posedge clk) disable iff (rst)
    clean <= raw)
    else $error("cleaned count exceeds raw count");

endmodule

FILE: sv/ab2lp_emit.sv
// Result stage: holds one result back to mark the last of each input byte,
// then drives the registered output channel. Depends on ab2lp_pkg.
module ab2lp_emit import ab2lp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  evt_t             evt,
  output logic             advance,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       item_kind,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] out_offset,
  output logic [CNT_W-1:0] unit_length,
  output logic [CNT_W-1:0] total_written,
  output logic             last_of_run
);

  evt_t hold;
  logic hold_valid;
  logic hold_last;
  logic out_free;
  logic push;

  assign out_free = !res_valid || !res_stall;
  assign advance  = !hold_valid || out_free;
  // the held result leaves once we know whether another result follows it
  assign push     = hold_valid && out_free && (hold_last || evt.valid || evt.cmd_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_last  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (out_free) begin
        res_valid <= push;
      end
      if (advance) begin
        if (evt.valid) begin
          hold_valid <= 1'b1;
          hold_last  <= evt.cmd_end;
        end else if (push) begin
          hold_valid <= 1'b0;
          hold_last  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.valid) begin
      hold <= evt;
    end
    if (push) begin
      item_kind     <= hold.kind;
      out_byte      <= hold.data;
      out_offset    <= hold.offset;
      unit_length   <= hold.length;
      total_written <= hold.total;
      last_of_run   <= hold_last || !evt.valid;
    end
  end

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    hold_last |-> hold_valid)
    else $error("last mark set on empty hold stage");

endmodule
